/* rtl/mcbm_pkg.sv */
// Package for the multi-channel byte mailbox: default sizes, command and
// status codes, the input and result word types and the controller links.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mcbm_pkg;

    localparam int NUM_MAILBOXES_DEF = 16;
    localparam int RING_BYTES_DEF    = 64;

    localparam int MAILBOX_W = 4;
    localparam int LENGTH_W  = 7;
    localparam int BYTE_W    = 8;

    typedef enum logic [1:0] {
        CMD_SEND_BEGIN = 2'd0,
        CMD_SEND_DATA  = 2'd1,
        CMD_RECEIVE    = 2'd2,
        CMD_CLOSE      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK          = 2'd0,
        STS_FULL        = 2'd1,
        STS_EMPTY       = 2'd2,
        STS_NO_OPEN_TX  = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                 command;
        logic [MAILBOX_W-1:0] mailbox;
        logic [LENGTH_W-1:0]  length;
        logic [BYTE_W-1:0]    data_byte;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   data_byte_res;
        logic                last;
        logic                wake_receivers;
        logic                wake_senders;
    } result_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic rd_step;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic recv_go;
        logic rd_last;
    } dp_status_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RECV = 3'b100
    } state_t;

endpackage

`default_nettype wire

/* rtl/mcbm_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mcbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/mcbm_ctrl.sv */
// Controller state machine of the mailbox: sequences accept, execute and
// the byte read-out of a receive. Depends on mcbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcbm_ctrl
    import mcbm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t sts,
    output ctrl_cmd_t       cmd,
    output logic            busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = sts.recv_go ? ST_RECV : ST_IDLE;
            end
            ST_RECV:
            begin
                if (sts.rd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign cmd.accept  = (state_reg == ST_IDLE) && start;
    assign cmd.exec    = (state_reg == ST_EXEC);
    assign cmd.rd_step = (state_reg == ST_RECV);

endmodule

`default_nettype wire

/* rtl/mcbm_dpath.sv */
// Datapath of the mailbox: per-mailbox head/tail/count RAM, the byte ring
// RAM, the open-send registers and the result register.
// Depends on mcbm_pkg and mcbm_ram.
`timescale 1ns / 1ps
`default_nettype none

module mcbm_dpath
    import mcbm_pkg::*;
#(
    parameter int NUM_MAILBOXES = NUM_MAILBOXES_DEF,
    parameter int RING_BYTES    = RING_BYTES_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ctrl_cmd_t cmd,
    input  wire item_t     item,
    output dp_status_t     sts,
    output logic           strobe,
    output result_t        result
);

    localparam int MB_W       = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1;
    localparam int PTR_W      = $clog2(RING_BYTES);
    localparam int CNT_W      = $clog2(RING_BYTES + 1);
    localparam int META_W     = 2 * PTR_W + CNT_W;
    localparam int RING_DEPTH = NUM_MAILBOXES * RING_BYTES;
    localparam int RA_W       = $clog2(RING_DEPTH);
    localparam int SUM_W      = LENGTH_W + 1;
    localparam int MB_IN      = 2 ** MAILBOX_W;

    // Mailbox field folded into range, worked out at elaboration.
    logic [MB_W-1:0] mb_lut [MB_IN];

    for (genvar g = 0; g < MB_IN; g++)
    begin : g_lut
        assign mb_lut[g] = MB_W'(g % NUM_MAILBOXES);
    end

    item_t                    item_reg;
    logic [MB_W-1:0]          mbx_reg;
    logic [MB_W-1:0]          mbx_next;
    logic [RA_W-1:0]          base_reg;
    logic [MB_W-1:0]          pend_mb_reg;
    logic [MB_W-1:0]          pend_mb_next;
    logic [CNT_W-1:0]         pend_rem_reg;
    logic [CNT_W-1:0]         pend_rem_next;
    logic [PTR_W-1:0]         rd_ptr_reg;
    logic [PTR_W-1:0]         rd_ptr_next;
    logic [CNT_W-1:0]         rd_rem_reg;
    logic [CNT_W-1:0]         rd_rem_next;
    logic [NUM_MAILBOXES-1:0] valid_reg;
    logic                     meta_valid_reg;
    result_t                  res_reg;
    result_t                  res_next;
    logic                     res_valid_reg;
    logic                     byte_valid_reg;
    logic                     byte_last_reg;

    logic [META_W-1:0] meta_rdata;
    logic [META_W-1:0] meta_word;
    logic [META_W-1:0] meta_wdata;
    logic              meta_we;
    logic [PTR_W-1:0]  head;
    logic [PTR_W-1:0]  tail;
    logic [CNT_W-1:0]  cnt;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W:0]    tail_sum;
    logic [PTR_W-1:0]  tail_new;
    logic [SUM_W-1:0]  cnt_ext;
    logic [SUM_W-1:0]  len_ext;
    logic              fits;
    logic              enough;
    logic              len_zero;
    logic              pend_open;
    logic              ring_we;
    logic [RA_W-1:0]   ring_waddr;
    logic [RA_W-1:0]   ring_raddr;
    logic [BYTE_W-1:0] ring_rdata;
    logic              recv_go;

    // Send data goes to the mailbox of the open send; other commands name one.
    assign mbx_next = (item.command == CMD_SEND_DATA) ? pend_mb_reg : mb_lut[item.mailbox];

    mcbm_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_MAILBOXES),
        .AW    (MB_W)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (mbx_reg),
        .wdata (meta_wdata),
        .re    (cmd.accept),
        .raddr (mbx_next),
        .rdata (meta_rdata)
    );

    mcbm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH),
        .AW    (RA_W)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (item_reg.data_byte),
        .re    (cmd.rd_step),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // A mailbox never written since reset reads as empty.
    assign meta_word = meta_valid_reg ? meta_rdata : '0;
    assign head      = meta_word[META_W-1 -: PTR_W];
    assign tail      = meta_word[CNT_W +: PTR_W];
    assign cnt       = meta_word[CNT_W-1:0];

    // The count holds written bytes only; the open reservation lives in pend_rem_reg.
    assign cnt_ext   = SUM_W'(cnt);
    assign len_ext   = SUM_W'(item_reg.length);
    assign fits      = (cnt_ext + len_ext) <= SUM_W'(RING_BYTES);
    assign enough    = len_ext <= cnt_ext;
    assign len_zero  = (item_reg.length == '0);
    assign pend_open = (pend_rem_reg != '0);

    assign head_inc = (head == PTR_W'(RING_BYTES - 1)) ? '0 : head + PTR_W'(1);
    assign tail_sum = {1'b0, tail} + (PTR_W + 1)'(item_reg.length);
    assign tail_new = (tail_sum >= (PTR_W + 1)'(RING_BYTES))
                      ? PTR_W'(tail_sum - (PTR_W + 1)'(RING_BYTES))
                      : PTR_W'(tail_sum);

    assign recv_go = (item_reg.command == CMD_RECEIVE) && enough && !len_zero;

    assign ring_we    = cmd.exec && (item_reg.command == CMD_SEND_DATA) && pend_open;
    assign ring_waddr = base_reg + RA_W'(head);
    assign ring_raddr = base_reg + RA_W'(rd_ptr_reg);

    always_comb
    begin
        meta_we       = 1'b0;
        meta_wdata    = meta_word;
        pend_mb_next  = pend_mb_reg;
        pend_rem_next = pend_rem_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_rem_next   = rd_rem_reg;
        res_next      = '{status: STS_OK, data_byte_res: '0, last: 1'b1,
                          wake_receivers: 1'b0, wake_senders: 1'b0};

        if (cmd.exec)
        begin
            unique case (item_reg.command)
                CMD_SEND_BEGIN:
                begin
                    // Any open send is abandoned; its unwritten part was never counted.
                    pend_rem_next = '0;
                    if (!fits)
                    begin
                        res_next.status = STS_FULL;
                    end
                    else
                    begin
                        pend_mb_next            = mbx_reg;
                        pend_rem_next           = CNT_W'(item_reg.length);
                        res_next.wake_receivers = len_zero;
                    end
                end
                CMD_SEND_DATA:
                begin
                    if (!pend_open)
                    begin
                        res_next.status = STS_NO_OPEN_TX;
                    end
                    else
                    begin
                        meta_we                 = 1'b1;
                        meta_wdata              = {head_inc, tail, cnt + CNT_W'(1)};
                        pend_rem_next           = pend_rem_reg - CNT_W'(1);
                        res_next.wake_receivers = (pend_rem_reg == CNT_W'(1));
                    end
                end
                CMD_RECEIVE:
                begin
                    if (!enough)
                    begin
                        res_next.status = STS_EMPTY;
                    end
                    else if (len_zero)
                    begin
                        res_next.wake_senders = 1'b1;
                    end
                    else
                    begin
                        meta_we     = 1'b1;
                        meta_wdata  = {head, tail_new, cnt - CNT_W'(item_reg.length)};
                        rd_ptr_next = tail;
                        rd_rem_next = CNT_W'(item_reg.length);
                    end
                end
                CMD_CLOSE:
                begin
                    meta_we    = 1'b1;
                    meta_wdata = '0;
                    if (pend_open && (pend_mb_reg == mbx_reg))
                    begin
                        pend_rem_next = '0;
                    end
                end
                default:
                begin
                    res_next.status = STS_OK;
                end
            endcase
        end
        else if (cmd.rd_step)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(RING_BYTES - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
            rd_rem_next = rd_rem_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_mb_reg    <= '0;
            pend_rem_reg   <= '0;
            valid_reg      <= '0;
            res_valid_reg  <= 1'b0;
            byte_valid_reg <= 1'b0;
            byte_last_reg  <= 1'b0;
        end
        else
        begin
            pend_mb_reg    <= pend_mb_next;
            pend_rem_reg   <= pend_rem_next;
            res_valid_reg  <= cmd.exec && !recv_go;
            byte_valid_reg <= cmd.rd_step;
            byte_last_reg  <= cmd.rd_step && sts.rd_last;
            if (meta_we)
            begin
                valid_reg[mbx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg       <= item;
            mbx_reg        <= mbx_next;
            base_reg       <= RA_W'(mbx_next * RING_BYTES);
            meta_valid_reg <= valid_reg[mbx_next];
        end
        rd_ptr_reg <= rd_ptr_next;
        rd_rem_reg <= rd_rem_next;
        res_reg    <= res_next;
    end

    assign sts.recv_go = recv_go;
    assign sts.rd_last = (rd_rem_reg == CNT_W'(1));

    assign strobe = res_valid_reg || byte_valid_reg;

    always_comb
    begin
        if (byte_valid_reg)
        begin
            result = '{status: STS_OK, data_byte_res: ring_rdata, last: byte_last_reg,
                       wake_receivers: 1'b0, wake_senders: byte_last_reg};
        end
        else
        begin
            result = res_reg;
        end
    end

endmodule

`default_nettype wire

/* rtl/multi_channel_byte_mailbox_top.sv */
// Top level of the multi-channel byte mailbox: controller plus datapath.
// Depends on mcbm_pkg, mcbm_ctrl and mcbm_dpath.
//
//   Channel   Handshake          Word
//   input     start / busy       item   (item_t: command, mailbox, length, data_byte)
//   result    strobe             result (result_t: status, data_byte_res, last, wakes)
//
// Send begin, send data and close pass through the accept and execute states
// before the next word can be accepted; the result shows in the cycle after
// the decision. A receive of n bytes then reads them out, one byte per cycle.
// The execute state waits on the registered read of the per-mailbox pointer RAM.
// Reset needs no clearing pass; per-mailbox valid bits stand in for it.
// Results cannot be stalled; each is shown for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_byte_mailbox_top
    import mcbm_pkg::*;
#(
    parameter int NUM_MAILBOXES = NUM_MAILBOXES_DEF,
    parameter int RING_BYTES    = RING_BYTES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire item_t item,
    output logic       strobe,
    output result_t    result
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    mcbm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    mcbm_dpath #(
        .NUM_MAILBOXES (NUM_MAILBOXES),
        .RING_BYTES    (RING_BYTES)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .sts    (sts),
        .strobe (strobe),
        .result (result)
    );

endmodule

`default_nettype wire

/* rtl/mcbm_checker.sv */
// Port-level checker for the mailbox top level, attached by bind.
// Depends on mcbm_pkg and multi_channel_byte_mailbox_top.
`timescale 1ns / 1ps
`default_nettype none

module mcbm_checker
    import mcbm_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire item_t   item,
    input wire logic    strobe,
    input wire result_t result
);

    // Every accepted non-receive word gives a final result, registered from its execute state.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.command != CMD_RECEIVE)) |=> ##1 (strobe && result.last))
        else $error("non-receive word did not give its result on time");

    // Received bytes come out back to back until the final one.
    a_stream_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |=> strobe)
        else $error("gap inside a receive byte stream");

    // An error status ends the word and carries no byte.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (result.status != STS_OK)) |->
            (result.last && (result.data_byte_res == '0) &&
             !result.wake_receivers && !result.wake_senders))
        else $error("error result not clean");

    // The block stays busy while a byte stream is still running.
    a_busy_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |-> busy)
        else $error("idle during a receive byte stream");

endmodule

bind multi_channel_byte_mailbox_top mcbm_checker u_mcbm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for multi_channel_byte_mailbox_top: directed and random
// command words, checked result by result against a behavioral mailbox tracker.
// Depends on mcbm_pkg and the mailbox RTL.
`timescale 1ns / 1ps

module tb;
    import mcbm_pkg::*;

    localparam int RANDOM_WORDS = 140;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;

    // Tracks the mailbox contents and holds the results still owed by the block.
    class mbox_tracker;
        logic [BYTE_W-1:0] ring [NUM_MAILBOXES_DEF][RING_BYTES_DEF];
        int head [NUM_MAILBOXES_DEF];
        int tail [NUM_MAILBOXES_DEF];
        int held [NUM_MAILBOXES_DEF];
        int open_mb;
        int open_left;
        result_t owed_results [$];
        int errors;
        int words_in;
        int results_out;
        int bytes_out;
        int full_cnt;
        int empty_cnt;
        int stray_cnt;

        function new();
            foreach (ring[m, i])
                ring[m][i] = '0;
            foreach (head[m])
            begin
                head[m] = 0;
                tail[m] = 0;
                held[m] = 0;
            end
            open_mb = 0;
            open_left = 0;
            errors = 0;
            words_in = 0;
            results_out = 0;
            bytes_out = 0;
            full_cnt = 0;
            empty_cnt = 0;
            stray_cnt = 0;
        endfunction

        // Bytes that a receive may take now; an open reservation is not readable.
        function int readable(int mb);
            int avail;
            avail = held[mb];
            if (open_left != 0 && open_mb == mb)
                avail = (avail >= open_left) ? avail - open_left : 0;
            return avail;
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction

        function void owe(status_t st, logic [BYTE_W-1:0] b, bit lst, bit wr, bit ws);
            result_t r;
            r.status = st;
            r.data_byte_res = b;
            r.last = lst;
            r.wake_receivers = wr;
            r.wake_senders = ws;
            owed_results.push_back(r);
        endfunction

        function void note_word(item_t w);
            int mb;
            int len;
            int avail;
            mb = int'(w.mailbox) % NUM_MAILBOXES_DEF;
            len = int'(w.length);
            words_in++;
            case (w.command)
                CMD_SEND_BEGIN:
                begin
                    // A new send abandons an open one and releases its unwritten bytes.
                    if (open_left != 0)
                    begin
                        held[open_mb] = (held[open_mb] >= open_left) ?
                                        held[open_mb] - open_left : 0;
                        open_left = 0;
                    end
                    if (held[mb] + len > RING_BYTES_DEF)
                    begin
                        owe(STS_FULL, '0, 1'b1, 1'b0, 1'b0);
                        full_cnt++;
                    end
                    else
                    begin
                        held[mb] += len;
                        open_mb = mb;
                        open_left = len;
                        owe(STS_OK, '0, 1'b1, len == 0, 1'b0);
                    end
                end
                CMD_SEND_DATA:
                begin
                    if (open_left == 0)
                    begin
                        owe(STS_NO_OPEN_TX, '0, 1'b1, 1'b0, 1'b0);
                        stray_cnt++;
                    end
                    else
                    begin
                        ring[open_mb][head[open_mb]] = w.data_byte;
                        head[open_mb] = (head[open_mb] + 1) % RING_BYTES_DEF;
                        open_left--;
                        owe(STS_OK, '0, 1'b1, open_left == 0, 1'b0);
                    end
                end
                CMD_RECEIVE:
                begin
                    avail = readable(mb);
                    if (avail < len)
                    begin
                        owe(STS_EMPTY, '0, 1'b1, 1'b0, 1'b0);
                        empty_cnt++;
                    end
                    else if (len == 0)
                        owe(STS_OK, '0, 1'b1, 1'b0, 1'b1);
                    else
                    begin
                        held[mb] -= len;
                        for (int i = 0; i < len; i++)
                        begin
                            owe(STS_OK, ring[mb][tail[mb]], i == len - 1, 1'b0, i == len - 1);
                            tail[mb] = (tail[mb] + 1) % RING_BYTES_DEF;
                        end
                        bytes_out += len;
                    end
                end
                CMD_CLOSE:
                begin
                    head[mb] = 0;
                    tail[mb] = 0;
                    held[mb] = 0;
                    for (int i = 0; i < RING_BYTES_DEF; i++)
                        ring[mb][i] = '0;
                    if (open_left != 0 && open_mb == mb)
                        open_left = 0;
                    owe(STS_OK, '0, 1'b1, 1'b0, 1'b0);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_word(result_t got);
            result_t exp;
            results_out++;
            if (owed_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result: status=%0d byte=%02h last=%0b wr=%0b ws=%0b",
                             got.status, got.data_byte_res, got.last,
                             got.wake_receivers, got.wake_senders);
                return;
            end
            exp = owed_results.pop_front();
            if (got.status !== exp.status || got.data_byte_res !== exp.data_byte_res ||
                got.last !== exp.last || got.wake_receivers !== exp.wake_receivers ||
                got.wake_senders !== exp.wake_senders)
            begin
                errors++;
                if (errors <= 10)
                    $display({"Mismatch: expected status=%0d byte=%02h last=%0b wr=%0b ws=%0b,",
                              " got status=%0d byte=%02h last=%0b wr=%0b ws=%0b"},
                             exp.status, exp.data_byte_res, exp.last,
                             exp.wake_receivers, exp.wake_senders,
                             got.status, got.data_byte_res, got.last,
                             got.wake_receivers, got.wake_senders);
            end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   item = '0;
    logic    strobe;
    result_t result;

    mbox_tracker sb = new();
    int cycles = 0;
    bit calm = 1'b0;

    multi_channel_byte_mailbox_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && strobe)
            sb.check_word(result);

    function int next_gap();
        if (calm)
            return 0;
        if ($urandom_range(0, 99) < 25)
            return $urandom_range(1, 18);
        return 0;
    endfunction

    // Called at a rising edge; start is only lowered when a gap is inserted.
    task automatic drive(input item_t w, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= w;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_word(w);
    endtask

    task automatic send_cmd(input cmd_t c, input int mb, input int len, input int b);
        item_t w;
        w.command = c;
        w.mailbox = mb[MAILBOX_W-1:0];
        w.length = len[LENGTH_W-1:0];
        w.data_byte = b[BYTE_W-1:0];
        drive(w, next_gap());
    endtask

    function int pick_box();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 1);
        return $urandom_range(0, 15);
    endfunction

    function int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 8);
        if (r < 92)
            return $urandom_range(9, RING_BYTES_DEF);
        return $urandom_range(RING_BYTES_DEF + 1, 127);
    endfunction

    task automatic receive_some(input int mb);
        int avail;
        int r;
        int len;
        avail = sb.readable(mb);
        r = $urandom_range(0, 99);
        if (r < 75)
            len = $urandom_range(0, avail);
        else if (r < 90)
            len = avail + $urandom_range(1, 4);
        else
            len = $urandom_range(0, 127);
        if (len > 127)
            len = 127;
        send_cmd(CMD_RECEIVE, mb, len, $urandom_range(0, 255));
    endtask

    // A send with its data words; sometimes cut short, sometimes interleaved
    // with a receive or a close on the same mailbox.
    task automatic send_sequence(input int mb);
        int len;
        int cut;
        len = pick_len();
        send_cmd(CMD_SEND_BEGIN, mb, len, $urandom_range(0, 255));
        if (sb.open_left != len || sb.open_mb != mb || len == 0)
            return;
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                receive_some(mb);
            else if ($urandom_range(0, 99) < 2)
                send_cmd(CMD_CLOSE, mb, $urandom_range(0, 127), $urandom_range(0, 255));
            send_cmd(CMD_SEND_DATA, $urandom_range(0, 15), $urandom_range(0, 127),
                     $urandom_range(0, 255));
        end
    endtask

    initial
    begin
        int base;
        int r;
        int mb;
        bit paused;
        paused = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: stray data, zero lengths, over-long lengths, byte
        // extremes, receive during an open send, abandoned send and close.
        send_cmd(CMD_SEND_DATA, 0, 0, 8'hFF);
        send_cmd(CMD_SEND_BEGIN, 0, 0, 0);
        send_cmd(CMD_RECEIVE, 0, 0, 0);
        send_cmd(CMD_RECEIVE, 15, 1, 0);
        send_cmd(CMD_SEND_BEGIN, 15, 127, 0);
        send_cmd(CMD_RECEIVE, 15, 100, 0);
        send_cmd(CMD_SEND_BEGIN, 15, 3, 0);
        send_cmd(CMD_SEND_DATA, 0, 0, 8'h00);
        send_cmd(CMD_SEND_DATA, 15, 127, 8'hFF);
        send_cmd(CMD_SEND_DATA, 0, 0, 8'hA5);
        send_cmd(CMD_RECEIVE, 15, 2, 0);
        send_cmd(CMD_SEND_BEGIN, 15, RING_BYTES_DEF, 0);
        send_cmd(CMD_SEND_BEGIN, 5, 4, 0);
        send_cmd(CMD_SEND_DATA, 0, 0, 8'h5A);
        send_cmd(CMD_RECEIVE, 5, 2, 0);
        send_cmd(CMD_RECEIVE, 5, 1, 0);
        send_cmd(CMD_SEND_BEGIN, 5, 0, 0);
        send_cmd(CMD_CLOSE, 15, 0, 0);
        send_cmd(CMD_RECEIVE, 15, 1, 0);
        send_cmd(CMD_SEND_BEGIN, 3, RING_BYTES_DEF, 0);
        for (int i = 0; i < RING_BYTES_DEF; i++)
            send_cmd(CMD_SEND_DATA, 0, 0, $urandom_range(0, 255));
        send_cmd(CMD_RECEIVE, 3, RING_BYTES_DEF, 0);

        base = sb.words_in;
        while (sb.words_in < base + RANDOM_WORDS)
        begin
            if (sb.words_in >= base + RANDOM_WORDS - 40)
                calm = 1'b1;
            else if ($urandom_range(0, 9) == 0)
                calm = !calm;
            if (!paused && sb.words_in >= base + RANDOM_WORDS / 2)
            begin
                // Hold the sender off until the block has answered everything.
                paused = 1'b1;
                start <= 1'b0;
                do
                    @(posedge clk);
                while (sb.outstanding() != 0);
            end
            r = $urandom_range(0, 99);
            mb = pick_box();
            if (r < 45)
                send_sequence(mb);
            else if (r < 78)
                receive_some(mb);
            else if (r < 86)
                send_cmd(CMD_CLOSE, mb, $urandom_range(0, 127), $urandom_range(0, 255));
            else if (r < 93)
                send_cmd(CMD_SEND_DATA, mb, $urandom_range(0, 127), $urandom_range(0, 255));
            else
                send_cmd(CMD_SEND_BEGIN, mb, $urandom_range(0, 127), $urandom_range(0, 255));
        end

        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d command words and checked %0d results (%0d bytes received).",
                 sb.words_in, sb.results_out, sb.bytes_out);
        $display("Saw %0d full, %0d empty and %0d stray-data answers; %0d mismatches.",
                 sb.full_cnt, sb.empty_cnt, sb.stray_cnt, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
